// ===== hdl/mrsp_pkg.sv =====
// shared types and constants for the midi running status parser
// no dependencies

package mrsp_pkg;

    localparam int BYTE_W = 8;
    localparam int DATA_W = 7;
    localparam int KIND_W = 4;

    // status byte codes
    localparam logic [BYTE_W-1:0] STATUS_NONE = 8'hF0;

    // message kinds from the high nibble of the status byte
    localparam logic [KIND_W-1:0] KIND_NOTE_OFF   = 4'h8;
    localparam logic [KIND_W-1:0] KIND_NOTE_ON    = 4'h9;
    localparam logic [KIND_W-1:0] KIND_POLY_PRESS = 4'hA;
    localparam logic [KIND_W-1:0] KIND_CTRL_CHG   = 4'hB;
    localparam logic [KIND_W-1:0] KIND_PROG_CHG   = 4'hC;
    localparam logic [KIND_W-1:0] KIND_CHAN_PRESS = 4'hD;
    localparam logic [KIND_W-1:0] KIND_PITCH      = 4'hE;
    localparam logic [KIND_W-1:0] KIND_SYSTEM     = 4'hF;

    localparam int MSG_W   = BYTE_W + 2 * DATA_W;
    localparam int TDATA_W = ((MSG_W + 7) / 8) * 8;

    typedef struct packed {
        logic [DATA_W-1:0] second_data;
        logic [DATA_W-1:0] first_data;
        logic [BYTE_W-1:0] msg_status;
    } msg_t;

endpackage

// ===== hdl/mrsp_parser.sv =====
// running status state and message assembly for one received byte
// depends on mrsp_pkg

module mrsp_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [mrsp_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        step,
    output logic                        emit,
    output mrsp_pkg::msg_t              msg
);
    import mrsp_pkg::*;

    logic [BYTE_W-1:0] status_reg, status_next;
    logic              ignore_reg, ignore_next;
    logic              count_reg, count_next;
    logic [DATA_W-1:0] held_reg, held_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= STATUS_NONE;
            ignore_reg <= 1'b1;
            count_reg  <= 1'b0;
            held_reg   <= '0;
        end else if (step) begin
            status_reg <= status_next;
            ignore_reg <= ignore_next;
            count_reg  <= count_next;
            held_reg   <= held_next;
        end
    end

    always_comb begin
        status_next      = status_reg;
        ignore_next      = ignore_reg;
        count_next       = count_reg;
        held_next        = held_reg;
        emit             = 1'b0;
        msg.msg_status   = status_reg;
        msg.first_data   = held_reg;
        msg.second_data  = rx_byte[DATA_W-1:0];
        if (rx_byte[BYTE_W-1]) begin
            if (rx_byte[BYTE_W-1 -: KIND_W] != KIND_SYSTEM) begin
                // channel status
                status_next = rx_byte;
                ignore_next = 1'b0;
                count_next  = 1'b0;
            end else if (!rx_byte[3]) begin
                // system common, realtime bytes fall through untouched
                status_next = rx_byte;
                ignore_next = 1'b1;
            end
        end else if (!ignore_reg) begin
            case (status_reg[BYTE_W-1 -: KIND_W])
                KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_PRESS,
                KIND_CTRL_CHG, KIND_PITCH: begin
                    if (!count_reg) begin
                        held_next  = rx_byte[DATA_W-1:0];
                        count_next = 1'b1;
                    end else begin
                        count_next = 1'b0;
                        emit       = 1'b1;
                    end
                end
                KIND_PROG_CHG, KIND_CHAN_PRESS: begin
                    count_next      = 1'b0;
                    emit            = 1'b1;
                    msg.first_data  = rx_byte[DATA_W-1:0];
                    msg.second_data = '0;
                end
                default: begin
                    count_next = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== hdl/midi_running_status_parser.sv =====
// top level: byte stream in, assembled channel-voice messages out
// depends on mrsp_pkg and mrsp_parser
// path: an input transfer fills the input register, is parsed, and its result is registered onto m_tvalid
// throughput: one byte per cycle when not stalled, set by the single parse stage
// a message-completing byte stalls only while the output register is full and held
// reset: synchronous active-low aresetn empties both registers, clears running status

module midi_running_status_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] msg_status, [14:8] first_data, [21:15] second_data, rest zero
    output logic [mrsp_pkg::TDATA_W-1:0] m_tdata
);
    import mrsp_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // output register
    logic              out_valid_reg;
    msg_t              out_msg_reg;

    logic              emit;
    msg_t              msg;
    logic              advance;
    logic              out_free;

    // output slot is free if empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;
    // a byte that makes no message never waits on the output side
    assign advance  = in_valid_reg && (out_free || !emit);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    mrsp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rx_byte (in_byte_reg),
        .step    (advance),
        .emit    (emit),
        .msg     (msg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && emit;
        end
    end

    // payload loads only with a new message
    always_ff @(posedge aclk) begin
        if (out_free && advance && emit) begin
            out_msg_reg <= msg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_msg_reg);

endmodule
